[src/accel_shake_detector_macros.svh]
// ----------------------------------------------------------------------------
// accel_shake_detector_macros: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_DETECTOR_MACROS_SVH
`define ACCEL_SHAKE_DETECTOR_MACROS_SVH

// same-cycle implication
`define ASD_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asd: same-cycle check failed");

// next-cycle implication
`define ASD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asd: next-cycle check failed");

`endif

[src/asd_pkg.sv]
// ----------------------------------------------------------------------------
// asd_pkg: shake detector shared types and constants
// Payload structs, register codes and configuration reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asd_pkg;

    localparam int ACCEL_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int LEVEL_W    = 15;
    localparam int COUNT_W    = 4;
    localparam int MAG_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [ACCEL_W-1:0] accel_t;
    typedef logic [STAMP_W-1:0]        stamp_t;
    typedef logic [LEVEL_W-1:0]        level_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [MAG_W-1:0]          mag_t;

    localparam count_t COUNT_MAX       = '1;
    localparam level_t GRAVITY_RESET   = 15'd2511;
    localparam level_t THRESHOLD_RESET = 15'd1280;
    localparam stamp_t WINDOW_RESET    = 32'd2000000;
    localparam stamp_t GAP_RESET       = 32'd100000;
    localparam count_t NEEDED_RESET    = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_LEVEL    = 3'd0,
        CFG_FORCE_THRESHOLD  = 3'd1,
        CFG_WINDOW_LENGTH_US = 3'd2,
        CFG_MIN_GAP_US       = 3'd3,
        CFG_SHAKES_NEEDED    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        accel_t accel_x;
        accel_t accel_y;
        accel_t accel_z;
        stamp_t timestamp_us;
        logic   menu_visible;
        logic   menu_ready;
    } sample_t;

    typedef struct packed {
        logic   trigger;
        logic   strong_sample;
        count_t shake_count;
    } result_t;

endpackage

[src/asd_sample_if.sv]
// ----------------------------------------------------------------------------
// asd_sample_if: accelerometer sample channel
// Valid/ready channel carrying one sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asd_sample_if;
    import asd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/asd_result_if.sv]
// ----------------------------------------------------------------------------
// asd_result_if: shake detector result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asd_result_if;
    import asd_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/asd_strength.sv]
// ----------------------------------------------------------------------------
// asd_strength: sample strength classifier
// Compares squared magnitude to squared upper and, if positive, lower bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asd_strength (
    input  asd_pkg::accel_t accel_x,
    input  asd_pkg::accel_t accel_y,
    input  asd_pkg::accel_t accel_z,
    input  asd_pkg::level_t gravity_level,
    input  asd_pkg::level_t force_threshold,
    output logic            strong_hit
);
    import asd_pkg::*;

    logic [ACCEL_W-1:0] abs_x;
    logic [ACCEL_W-1:0] abs_y;
    logic [ACCEL_W-1:0] abs_z;
    mag_t               sq_x;
    mag_t               sq_y;
    mag_t               sq_z;
    mag_t               mag2;
    logic [LEVEL_W:0]   hi_level;
    level_t             lo_level;
    mag_t               hi_sq;
    mag_t               lo_sq;
    logic               has_lower;

    // most negative input gives 0x8000, which reads correctly as unsigned
    assign abs_x = accel_x[ACCEL_W-1] ? (~accel_x + 1'b1) : accel_x;
    assign abs_y = accel_y[ACCEL_W-1] ? (~accel_y + 1'b1) : accel_y;
    assign abs_z = accel_z[ACCEL_W-1] ? (~accel_z + 1'b1) : accel_z;

    assign sq_x = MAG_W'(abs_x) * MAG_W'(abs_x);
    assign sq_y = MAG_W'(abs_y) * MAG_W'(abs_y);
    assign sq_z = MAG_W'(abs_z) * MAG_W'(abs_z);

    // three squares of at most 2^30 each never carry out of 32 bits
    assign mag2 = sq_x + sq_y + sq_z;

    assign hi_level  = {1'b0, gravity_level} + {1'b0, force_threshold};
    assign lo_level  = gravity_level - force_threshold;
    assign has_lower = gravity_level > force_threshold;
    assign hi_sq     = MAG_W'(hi_level) * MAG_W'(hi_level);
    assign lo_sq     = MAG_W'(lo_level) * MAG_W'(lo_level);

    assign strong_hit = (mag2 > hi_sq) || (has_lower && (mag2 < lo_sq));

endmodule

[src/accel_shake_detector.sv]
// ----------------------------------------------------------------------------
// accel_shake_detector: accelerometer shake gesture detector
// pipeline: sample held in the input register, then the result in the output register
// throughput: one sample per cycle while results are taken, set by the single classify-and-update pass
// reset: rst_n async low; config registers to defaults, count and timestamps to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "accel_shake_detector_macros.svh"

module accel_shake_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    asd_sample_if.sink                         sample,
    asd_result_if.source                       result,
    input  logic                               cfg_we,
    input  asd_pkg::cfg_index_t                cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import asd_pkg::*;

    level_t  gravity_reg;
    level_t  threshold_reg;
    stamp_t  window_len_reg;
    stamp_t  min_gap_reg;
    count_t  needed_reg;

    logic    s1_valid_reg;
    sample_t s1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    stamp_t  window_start_reg;
    stamp_t  window_start_next;
    stamp_t  last_shake_reg;
    stamp_t  last_shake_next;
    count_t  count_reg;
    count_t  count_next;

    logic    advance;
    logic    process;
    logic    strong_hit;
    logic    expire;
    logic    counted;
    logic    fire;
    stamp_t  win_elapsed;
    stamp_t  since_last;
    count_t  count_windowed;
    count_t  count_bumped;
    result_t out_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg    <= GRAVITY_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            window_len_reg <= WINDOW_RESET;
            min_gap_reg    <= GAP_RESET;
            needed_reg     <= NEEDED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRAVITY_LEVEL:    gravity_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_FORCE_THRESHOLD:  threshold_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_WINDOW_LENGTH_US: window_len_reg <= cfg_data[STAMP_W-1:0];
                CFG_MIN_GAP_US:       min_gap_reg    <= cfg_data[STAMP_W-1:0];
                CFG_SHAKES_NEEDED:    needed_reg     <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // output register frees when empty or taken; input register behind it
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || advance;
    assign process      = s1_valid_reg && advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    asd_strength u_strength (
        .accel_x         (s1_reg.accel_x),
        .accel_y         (s1_reg.accel_y),
        .accel_z         (s1_reg.accel_z),
        .gravity_level   (gravity_reg),
        .force_threshold (threshold_reg),
        .strong_hit      (strong_hit)
    );

    // elapsed times wrap modulo 2^32
    assign win_elapsed = s1_reg.timestamp_us - window_start_reg;
    assign since_last  = s1_reg.timestamp_us - last_shake_reg;
    assign expire      = win_elapsed > window_len_reg;
    assign counted     = strong_hit && (since_last > min_gap_reg);

    always_comb
    begin
        count_windowed    = expire ? '0 : count_reg;
        window_start_next = expire ? s1_reg.timestamp_us : window_start_reg;

        count_bumped    = count_windowed;
        last_shake_next = last_shake_reg;
        if (counted)
        begin
            if (count_windowed != COUNT_MAX)
            begin
                count_bumped = count_windowed + 1'b1;
            end
            last_shake_next = s1_reg.timestamp_us;
        end

        fire = (count_bumped >= needed_reg) && !s1_reg.menu_visible && s1_reg.menu_ready;
        count_next = fire ? '0 : count_bumped;

        out_next.trigger       = fire;
        out_next.strong_sample = strong_hit;
        out_next.shake_count   = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            window_start_reg <= '0;
            last_shake_reg   <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (process)
            begin
                window_start_reg <= window_start_next;
                last_shake_reg   <= last_shake_next;
                count_reg        <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_reg <= sample.data;
        end
        if (process)
        begin
            out_reg <= out_next;
        end
    end

    `ASD_ASSERT_IMPLIES(a_stall_only_when_full, !sample.ready, s1_valid_reg && out_valid_reg && !result.ready)
    `ASD_ASSERT_IMPLIES(a_trigger_clears_count, out_valid_reg && out_reg.trigger, out_reg.shake_count == '0)
    `ASD_ASSERT_NEXT(a_result_mirrors_count, process, out_reg.shake_count == count_reg)
    `ASD_ASSERT_NEXT(a_weak_never_counts, process && !strong_hit, count_reg <= $past(count_reg))

endmodule
